### hw/rtl/dda_line_rasterizer_core_assert.svh
// assertion macros for the dda line rasterizer
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define DDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must be followed by another in the next cycle
`define DDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/dda_pkg.sv
package dda_pkg;

    // frame limits and slope format
    localparam int MAX_WIDTH       = 64;
    localparam int MAX_HEIGHT      = 64;
    localparam int SLOPE_FRAC_BITS = 16;

    // field widths
    localparam int COORD_W     = 6;
    localparam int DIM_W       = 7;
    localparam int ADDR_W      = 12;
    localparam int COLOR_W     = 8;
    localparam int CFG_INDEX_W = 1;

    // carried coordinate: sign, guard bits, integer part, fraction
    localparam int ACC_W     = COORD_W + SLOPE_FRAC_BITS + 3;
    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = COORD_W + SLOPE_FRAC_BITS;
    localparam int QUO_W     = DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RASTER_WIDTH,
        REG_RASTER_HEIGHT
    } dda_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_RUN
    } dda_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic acc_init;
        logic emit;
    } dda_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic last_step;
        logic out_free;
    } dda_stat_t;

    // one line request
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] fill_red;
        logic [COLOR_W-1:0] fill_green;
        logic [COLOR_W-1:0] fill_blue;
    } dda_line_t;

    // frame dimension limited to 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        return r;
    endfunction

    // coordinate saturated to lim-1
    function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v,
                                                       logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] lim_m1;
        lim_m1 = lim - DIM_W'(1);
        return ({1'b0, v} > lim_m1) ? lim_m1[COORD_W-1:0] : v;
    endfunction

endpackage

### hw/rtl/dda_if.sv
// line request channel
interface dda_line_if;
    import dda_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] fill_red;
    logic [COLOR_W-1:0] fill_green;
    logic [COLOR_W-1:0] fill_blue;

    modport source (output valid, start_x, start_y, end_x, end_y,
                    fill_red, fill_green, fill_blue, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y,
                    fill_red, fill_green, fill_blue, output ready);
endinterface

// pixel write channel
interface dda_pixel_if;
    import dda_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  frame_address;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               last_pixel;

    modport source (output valid, pixel_x, pixel_y, frame_address, out_red, out_green,
                    out_blue, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, frame_address, out_red, out_green,
                    out_blue, last_pixel, output ready);
endinterface

// register write channel
interface dda_cfg_if;
    import dda_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [DIM_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/dda_ctrl.sv
`include "dda_line_rasterizer_core_assert.svh"

module dda_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dda_pkg::dda_stat_t stat,
    output dda_pkg::dda_cmd_t  cmd
);
    import dda_pkg::*;

    dda_state_t state_reg;
    dda_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.acc_init = 1'b1;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free && stat.last_step)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `DDA_ASSERT_NEXT(a_div_holds, clk, rst_n, state_reg == ST_DIV && !stat.div_last, state_reg == ST_DIV, "divider left early")
    `DDA_ASSERT_NEXT(a_last_frees, clk, rst_n, cmd.emit && stat.last_step, in_ready, "not ready after final pixel")
    `DDA_ASSERT_NEXT(a_one_line, clk, rst_n, in_valid && in_ready, !in_ready, "second line taken while busy")

endmodule

### hw/rtl/dda_datapath.sv
`include "dda_line_rasterizer_core_assert.svh"

module dda_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dda_pkg::dda_line_t                line,
    input  dda_pkg::dda_cmd_t                 cmd,
    output dda_pkg::dda_stat_t                stat,
    input  logic                              cfg_valid,
    input  dda_pkg::dda_reg_t                 cfg_index,
    input  logic [dda_pkg::DIM_W-1:0]         cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dda_pkg::COORD_W-1:0]       pixel_x,
    output logic [dda_pkg::COORD_W-1:0]       pixel_y,
    output logic [dda_pkg::ADDR_W-1:0]        frame_address,
    output logic [dda_pkg::COLOR_W-1:0]       out_red,
    output logic [dda_pkg::COLOR_W-1:0]       out_green,
    output logic [dda_pkg::COLOR_W-1:0]       out_blue,
    output logic                              last_pixel
);
    import dda_pkg::*;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] w_lim;
    logic [DIM_W-1:0] h_lim;

    // line setup values
    logic [COORD_W-1:0]       sx, sy, ex, ey;
    logic signed [COORD_W:0]  dx, dy;
    logic [COORD_W-1:0]       adx, ady;
    logic                     steep;
    logic                     swap;
    logic [COORD_W-1:0]       major_start, major_stop, minor_start;
    logic [COORD_W-1:0]       num, den;

    // line state
    logic                     steep_reg;
    logic                     neg_reg;
    logic [COORD_W-1:0]       den_reg;
    logic [COORD_W-1:0]       major_reg;
    logic [COORD_W-1:0]       major_end_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  step_reg;
    logic [COLOR_W-1:0]       red_reg, green_reg, blue_reg;

    // divider
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic [COORD_W-1:0]       rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [COORD_W:0]         trial;
    logic                     trial_ge;
    logic [COORD_W:0]         trial_sub;
    logic signed [ACC_W-1:0]  quo_ext;

    // pixel formation
    logic signed [ACC_W-1:0]             rnd;
    logic [ACC_W-SLOPE_FRAC_BITS-1:0]    rint;
    logic [DIM_W-1:0]                    lim_m1;
    logic [COORD_W-1:0]                  minor;
    logic [COORD_W-1:0]                  px, py;
    logic [DIM_W-1:0]                    row_full;
    logic [ADDR_W:0]                     addr_full;

    // output register
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   pixel_x_reg, pixel_y_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [COLOR_W-1:0]   out_red_reg, out_green_reg, out_blue_reg;
    logic                 last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RASTER_WIDTH:  width_reg  <= cfg_data;
                REG_RASTER_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_lim = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_lim = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    // endpoint saturation, direction choice and swap
    always_comb
    begin
        sx    = clamp_coord(line.start_x, w_lim);
        sy    = clamp_coord(line.start_y, h_lim);
        ex    = clamp_coord(line.end_x, w_lim);
        ey    = clamp_coord(line.end_y, h_lim);
        dx    = $signed({1'b0, ex}) - $signed({1'b0, sx});
        dy    = $signed({1'b0, ey}) - $signed({1'b0, sy});
        adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        steep = ady > adx;
        if (steep)
        begin
            // step y downward from the upper endpoint
            swap        = ey > sy;
            major_start = swap ? ey : sy;
            major_stop  = swap ? sy : ey;
            minor_start = swap ? ex : sx;
            num         = adx;
            den         = ady;
        end
        else
        begin
            // step x upward from the left endpoint
            swap        = sx > ex;
            major_start = swap ? ex : sx;
            major_stop  = swap ? sx : ex;
            minor_start = swap ? ey : sy;
            num         = ady;
            den         = (adx == '0) ? COORD_W'(1) : adx;
        end
    end

    // one restoring divide step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        trial_ge  = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
        quo_ext   = $signed(ACC_W'(quo_reg));
    end

    // divider counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.load)
            div_cnt_reg <= '0;
        else if (cmd.div_step && !stat.div_last)
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
    end

    // line registers, divider data and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            steep_reg     <= steep;
            neg_reg       <= dx[COORD_W] ^ dy[COORD_W];
            den_reg       <= den;
            major_reg     <= major_start;
            major_end_reg <= major_stop;
            acc_reg       <= $signed({3'b000, minor_start, {SLOPE_FRAC_BITS{1'b0}}});
            rem_reg       <= '0;
            quo_reg       <= {num, {SLOPE_FRAC_BITS{1'b0}}};
            red_reg       <= line.fill_red;
            green_reg     <= line.fill_green;
            blue_reg      <= line.fill_blue;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.acc_init)
            step_reg <= neg_reg ? -quo_ext : quo_ext;
        if (cmd.emit)
        begin
            acc_reg   <= steep_reg ? acc_reg - step_reg : acc_reg + step_reg;
            major_reg <= steep_reg ? major_reg - COORD_W'(1) : major_reg + COORD_W'(1);
        end
    end

    // round half up and saturate the carried coordinate
    always_comb
    begin
        rnd    = acc_reg + $signed(ACC_W'(1) << (SLOPE_FRAC_BITS - 1));
        rint   = rnd[ACC_W-1:SLOPE_FRAC_BITS];
        lim_m1 = steep_reg ? (w_lim - DIM_W'(1)) : (h_lim - DIM_W'(1));
        if (rnd[ACC_W-1])
            minor = '0;
        else if (rint > (ACC_W-SLOPE_FRAC_BITS)'(lim_m1))
            minor = lim_m1[COORD_W-1:0];
        else
            minor = rint[COORD_W-1:0];
        px        = steep_reg ? minor : major_reg;
        py        = steep_reg ? major_reg : minor;
        row_full  = h_lim - DIM_W'(1) - {1'b0, py};
        addr_full = (ADDR_W+1)'(row_full[COORD_W-1:0]) * (ADDR_W+1)'(w_lim)
                    + (ADDR_W+1)'(px);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_x_reg   <= px;
            pixel_y_reg   <= py;
            addr_reg      <= addr_full[ADDR_W-1:0];
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            last_reg      <= stat.last_step;
        end
    end

    // status back to the controller
    assign stat.div_last  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign stat.last_step = major_reg == major_end_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign frame_address = addr_reg;
    assign out_red       = out_red_reg;
    assign out_green     = out_green_reg;
    assign out_blue      = out_blue_reg;
    assign last_pixel    = last_reg;

    `DDA_ASSERT_NEXT(a_emit_fills, clk, rst_n, cmd.emit, out_valid_reg, "pixel beat lost")
    `DDA_ASSERT_NEXT(a_load_clears, clk, rst_n, cmd.load, div_cnt_reg == '0,
                     "divider not restarted")
    `DDA_ASSERT_NEXT(a_div_counts, clk, rst_n, cmd.div_step && !stat.div_last,
                     div_cnt_reg == $past(div_cnt_reg) + DIV_CNT_W'(1),
                     "divider count skipped")

endmodule

### hw/rtl/dda_line_rasterizer_core.sv
// dda line rasterizer
// line_in takes one line per beat: two endpoints (y counted from the bottom)
// and an rgb color. pixel_out gives one pixel write per beat with x, y, the
// frame address (height-1-y)*width+x, the color and last_pixel on the final
// pixel of the line. cfg writes raster_width (index 0) and raster_height
// (index 1); write them only while no line is in flight.
// per line: the line is taken, then the bit-serial slope divider runs (one
// quotient bit per cycle), then a setup step, then one pixel per cycle while
// pixel_out is not stalled; a line has n pixels (1 to 64), and its first
// pixel shows on pixel_out once the divider and setup steps are done.
// only one line is drawn at a time: line_in.ready is high between lines, and
// the next line may be taken while the final pixel still waits in the output
// register.
// a stall on pixel_out holds the current pixel and pauses the stepping; no
// pixel is dropped or repeated.
// reset empties the output register, returns to waiting for a line and sets
// width and height to 64.
module dda_line_rasterizer_core (
    input  logic        clk,
    input  logic        rst_n,
    dda_line_if.sink    line_in,
    dda_pixel_if.source pixel_out,
    dda_cfg_if.sink     cfg
);
    import dda_pkg::*;

    dda_cmd_t  cmd;
    dda_stat_t stat;
    dda_line_t line;

    // gather the line beat
    assign line.start_x    = line_in.start_x;
    assign line.start_y    = line_in.start_y;
    assign line.end_x      = line_in.end_x;
    assign line.end_y      = line_in.end_y;
    assign line.fill_red   = line_in.fill_red;
    assign line.fill_green = line_in.fill_green;
    assign line.fill_blue  = line_in.fill_blue;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (line_in.valid),
        .in_ready (line_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dda_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .line          (line),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg.valid),
        .cfg_index     (dda_reg_t'(cfg.index)),
        .cfg_data      (cfg.data),
        .out_valid     (pixel_out.valid),
        .out_ready     (pixel_out.ready),
        .pixel_x       (pixel_out.pixel_x),
        .pixel_y       (pixel_out.pixel_y),
        .frame_address (pixel_out.frame_address),
        .out_red       (pixel_out.out_red),
        .out_green     (pixel_out.out_green),
        .out_blue      (pixel_out.out_blue),
        .last_pixel    (pixel_out.last_pixel)
    );

endmodule
